FILE: rtl/palette_image_stream_decoder_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the palette image stream decoder
// Concurrent checks clocked on clock, switched off while reset is high.
// ---------------------------------------------------------------------------
`ifndef PALETTE_IMAGE_STREAM_DECODER_ASSERT_SVH
`define PALETTE_IMAGE_STREAM_DECODER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PISD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pisd: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define PISD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pisd: next-cycle check failed");

`endif

FILE: rtl/pisd_pkg.sv
// ---------------------------------------------------------------------------
// pisd_pkg
// Shared types and constants of the palette image stream decoder.
// ---------------------------------------------------------------------------
package pisd_pkg;

   localparam int unsigned MAX_DIMENSION = 4096;

   localparam int DIM_W    = 13;
   localparam int COUNT_W  = 25;
   localparam int POS_W    = 33;
   localparam int OFFSET_W = 35;
   localparam int SUM_W    = 36;
   localparam int LEN_W    = 32;
   localparam int WORD_W   = 32;
   localparam int PAL_DEPTH = 256;
   localparam int PAL_AW    = 8;

   localparam logic [POS_W-1:0]    HEADER_BYTES = 33'd32;
   localparam logic [POS_W-1:0]    HEADER_LAST  = 33'd31;
   localparam logic [POS_W-1:0]    PALETTE_END  = 33'd1056;
   localparam logic [9:0]          PALETTE_BASE = 10'd32;
   localparam logic [OFFSET_W-1:0] PLAIN_OFFSET = 35'd1056;
   // 32 + 1024 - 4: added to flags * 4
   localparam logic [OFFSET_W-1:0] EXTRA_BASE   = 35'd1052;

   localparam logic [2:0] WORD_WIDTH  = 3'd1;
   localparam logic [2:0] WORD_HEIGHT = 3'd2;
   localparam logic [2:0] WORD_FLAGS  = 3'd4;

   localparam logic [WORD_W-1:0] FLAGS_PLAIN    = 32'd1;
   localparam logic [WORD_W-1:0] FLAGS_FIRST_EXTRA = 32'd3;

   typedef enum logic [2:0] {
      ST_PIXEL     = 3'd0,
      ST_HEADER_OK = 3'd1,
      ST_BAD_DIM   = 3'd2,
      ST_BAD_FLAGS = 3'd3,
      ST_TOO_SHORT = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEADER,
      PH_BODY,
      PH_DONE
   } phase_type;

   typedef struct packed {
      status_type         status;
      logic [DIM_W-1:0]   image_width;
      logic [DIM_W-1:0]   image_height;
      logic               last_pixel;
      logic               pixel;
   } res_meta_type;

   typedef struct packed {
      logic         valid;
      res_meta_type meta;
   } res_beat_type;

   function automatic logic [DIM_W-1:0] checked_dim(input logic [WORD_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0 || v > WORD_W'(MAX_DIMENSION)) begin
         r = '0;
      end else begin
         r = v[DIM_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/pisd_req_if.sv
// ---------------------------------------------------------------------------
// pisd_req_if
// Byte stream channel: one file byte and its start-of-file mark per beat.
// ---------------------------------------------------------------------------
interface pisd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;

   modport source (output valid, output data_byte, output first_byte, input ready);
   modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

FILE: rtl/pisd_rsp_if.sv
// ---------------------------------------------------------------------------
// pisd_rsp_if
// Result channel: header status or one RGBA pixel per beat.
// ---------------------------------------------------------------------------
interface pisd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [7:0]  alpha;
   logic [12:0] image_width;
   logic [12:0] image_height;
   logic        last_pixel;

   modport source (output valid, output status, output red, output green, output blue,
                   output alpha, output image_width, output image_height,
                   output last_pixel, input ready);
   modport sink   (input valid, input status, input red, input green, input blue,
                   input alpha, input image_width, input image_height,
                   input last_pixel, output ready);
endinterface

FILE: rtl/pisd_csr_if.sv
// ---------------------------------------------------------------------------
// pisd_csr_if
// Register write channel carrying the file length.
// ---------------------------------------------------------------------------
interface pisd_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] file_length;

   modport source (output valid, output file_length, input ready);
   modport sink   (input valid, input file_length, output ready);
endinterface

FILE: rtl/pisd_ram.sv
// ---------------------------------------------------------------------------
// pisd_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module pisd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold read data between reads
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: rtl/pisd_ctrl.sv
// ---------------------------------------------------------------------------
// pisd_ctrl
// File parser: header collection and checks, palette fill, pixel lookup.
// ---------------------------------------------------------------------------
module pisd_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [7:0]                    data_byte,
   input  logic                          first_byte,
   input  logic                          csr_write,
   input  logic [pisd_pkg::LEN_W-1:0]    csr_data,
   output pisd_pkg::res_beat_type        beat,
   output logic                          wr_en,
   output logic [pisd_pkg::PAL_AW-1:0]   wr_addr,
   output logic [pisd_pkg::WORD_W-1:0]   wr_data,
   output logic                          rd_en,
   output logic [pisd_pkg::PAL_AW-1:0]   rd_addr
);
   import pisd_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [WORD_W-1:0]      shift_ff, shift_in;
   logic [DIM_W-1:0]       width_ff, width_in;
   logic [DIM_W-1:0]       height_ff, height_in;
   logic [OFFSET_W-1:0]    offset_ff, offset_in;
   logic [COUNT_W-1:0]     remaining_ff, remaining_in;
   logic [LEN_W-1:0]       file_len_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic [SUM_W-1:0]       sum_ff;

   phase_type              eff_phase;
   logic [POS_W-1:0]       eff_pos;
   logic [WORD_W-1:0]      eff_shift;
   logic [WORD_W-1:0]      shift_new;
   logic [9:0]             rel;
   logic [OFFSET_W-1:0]    flags_offset;
   logic [2*DIM_W-1:0]     product;
   logic                   short_file;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pos_ff       <= '0;
         shift_ff     <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         offset_ff    <= '0;
         remaining_ff <= '0;
         file_len_ff  <= '0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         shift_ff     <= shift_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         offset_ff    <= offset_in;
         remaining_ff <= remaining_in;
         if (csr_write) begin
            file_len_ff <= csr_data;
         end
      end
   end

   // pixel count and end of pixel area, settled long before the last header byte
   assign product = width_ff * height_ff;

   always_ff @(posedge clock) begin
      count_ff <= product[COUNT_W-1:0];
      sum_ff   <= SUM_W'(offset_ff) + SUM_W'(count_ff);
   end

   // a start mark restarts the file at byte 0
   always_comb begin
      if (first_byte) begin
         eff_phase = PH_HEADER;
         eff_pos   = '0;
         eff_shift = '0;
      end else begin
         eff_phase = phase_ff;
         eff_pos   = pos_ff;
         eff_shift = shift_ff;
      end
   end

   assign shift_new  = {data_byte, eff_shift[WORD_W-1:8]};
   assign rel        = eff_pos[9:0] - PALETTE_BASE;
   assign short_file = file_len_ff < LEN_W'(HEADER_BYTES);

   always_comb begin
      if (shift_new == FLAGS_PLAIN) begin
         flags_offset = PLAIN_OFFSET;
      end else if (shift_new < FLAGS_FIRST_EXTRA) begin
         flags_offset = '0;
      end else begin
         flags_offset = {1'b0, shift_new, 2'b00} + EXTRA_BASE;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      shift_in     = shift_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      offset_in    = offset_ff;
      remaining_in = remaining_ff;
      beat         = '0;
      wr_en        = 1'b0;
      wr_addr      = rel[9:2];
      wr_data      = shift_new;
      rd_en        = 1'b0;
      rd_addr      = data_byte;

      if (accept) begin
         if (first_byte) begin
            phase_in     = PH_HEADER;
            pos_in       = '0;
            shift_in     = '0;
            width_in     = '0;
            height_in    = '0;
            offset_in    = '0;
            remaining_in = '0;
         end

         if (first_byte && short_file) begin
            phase_in           = PH_DONE;
            beat.valid         = 1'b1;
            beat.meta.status   = ST_TOO_SHORT;
         end else begin
            unique case (eff_phase)
               PH_HEADER: begin
                  pos_in   = eff_pos + 1'b1;
                  shift_in = shift_new;
                  if (eff_pos[1:0] == 2'd3) begin
                     unique case (eff_pos[4:2])
                        WORD_WIDTH:  width_in  = checked_dim(shift_new);
                        WORD_HEIGHT: height_in = checked_dim(shift_new);
                        WORD_FLAGS:  offset_in = flags_offset;
                        default: ;
                     endcase
                  end
                  if (eff_pos == HEADER_LAST) begin
                     beat.valid = 1'b1;
                     phase_in   = PH_DONE;
                     priority if (width_ff == '0 || height_ff == '0) begin
                        beat.meta.status = ST_BAD_DIM;
                     end else if (offset_ff == '0) begin
                        beat.meta.status = ST_BAD_FLAGS;
                     end else if (sum_ff > SUM_W'(file_len_ff)) begin
                        beat.meta.status = ST_TOO_SHORT;
                     end else begin
                        phase_in               = PH_BODY;
                        remaining_in           = count_ff;
                        shift_in               = '0;
                        beat.meta.status       = ST_HEADER_OK;
                        beat.meta.image_width  = width_ff;
                        beat.meta.image_height = height_ff;
                     end
                  end
               end
               PH_BODY: begin
                  pos_in = eff_pos + 1'b1;
                  if (eff_pos < PALETTE_END) begin
                     shift_in = shift_new;
                     if (rel[1:0] == 2'd3) begin
                        wr_en = 1'b1;
                     end
                  end else if (OFFSET_W'(eff_pos) >= offset_ff) begin
                     // pixel index: look up the palette entry
                     rd_en                = 1'b1;
                     beat.valid           = 1'b1;
                     beat.meta.status     = ST_PIXEL;
                     beat.meta.pixel      = 1'b1;
                     beat.meta.last_pixel = (remaining_ff <= COUNT_W'(1));
                     if (remaining_ff != '0) begin
                        remaining_in = remaining_ff - 1'b1;
                     end
                     if (remaining_ff <= COUNT_W'(1)) begin
                        phase_in = PH_DONE;
                     end
                  end
               end
               PH_IDLE, PH_DONE: ;
            endcase
         end
      end
   end

endmodule

FILE: rtl/pisd_out.sv
// ---------------------------------------------------------------------------
// pisd_out
// Palette read stage and output register of the result channel.
// ---------------------------------------------------------------------------
module pisd_out (
   input  logic                         clock,
   input  logic                         reset,
   input  pisd_pkg::res_beat_type       beat,
   input  logic [pisd_pkg::WORD_W-1:0]  rd_data,
   output logic                         in_ready,
   pisd_rsp_if.source                   rsp
);
   import pisd_pkg::*;

   logic               s1_valid_ff, s1_valid_in;
   res_meta_type       s1_meta_ff;
   logic               out_valid_ff, out_valid_in;
   res_meta_type       out_meta_ff;
   logic [WORD_W-1:0]  out_rgba_ff;
   logic               s1_move;

   assign s1_move  = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign in_ready = !s1_valid_ff || s1_move;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (in_ready) begin
         s1_valid_in = beat.valid;
      end
      out_valid_in = out_valid_ff;
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         s1_meta_ff <= beat.meta;
      end
      if (s1_move) begin
         out_meta_ff <= s1_meta_ff;
         out_rgba_ff <= s1_meta_ff.pixel ? rd_data : '0;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.status       = out_meta_ff.status;
   assign rsp.red          = out_rgba_ff[7:0];
   assign rsp.green        = out_rgba_ff[15:8];
   assign rsp.blue         = out_rgba_ff[23:16];
   assign rsp.alpha        = out_rgba_ff[31:24];
   assign rsp.image_width  = out_meta_ff.image_width;
   assign rsp.image_height = out_meta_ff.image_height;
   assign rsp.last_pixel   = out_meta_ff.last_pixel;

endmodule

FILE: rtl/palette_image_stream_decoder.sv
// ---------------------------------------------------------------------------
// palette_image_stream_decoder
// Streams an 8-bit palette image file and emits header status and RGBA pixels.
// ---------------------------------------------------------------------------
// Usage:
//   csr_bus  : write file_length before the file starts; always ready.
//   req_bus  : one file byte per beat; first_byte marks byte 0 of a file and
//              restarts decoding from any point.
//   rsp_bus  : one beat after header byte 31 (status 1 with the image size, or
//              an error status 2, 3 or 4), then one RGBA beat per pixel byte,
//              last_pixel set on the final one. A file shorter than 32 bytes
//              gets status 4 on its first byte.
//   Throughput: one byte per cycle while rsp_bus is not stalled;
//   header, palette and skipped bytes produce no beat.
//   Path: a result beat reaches rsp_bus through the read stage and then the
//   output register; the palette read and the read stage load on the
//   accepting edge, and a stalled rsp_bus can hold the beat in the read stage.
//   Stall: a stalled rsp_bus holds its beat; one more result waits in the read
//   stage and req_bus ready drops only once both are full.
//   Reset: parser returns to idle, file_length clears; the palette RAM keeps
//   its contents and needs no clearing, as each file rewrites it before use.
// ---------------------------------------------------------------------------
module palette_image_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   pisd_req_if.sink    req_bus,
   pisd_rsp_if.source  rsp_bus,
   pisd_csr_if.sink    csr_bus
);
   import pisd_pkg::*;

   logic               accept;
   logic               in_ready;
   res_beat_type       beat;
   logic               wr_en;
   logic [PAL_AW-1:0]  wr_addr;
   logic [WORD_W-1:0]  wr_data;
   logic               rd_en;
   logic [PAL_AW-1:0]  rd_addr;
   logic [WORD_W-1:0]  rd_data;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = in_ready;
   assign accept        = req_bus.valid && in_ready;

   pisd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_bus.data_byte),
      .first_byte (req_bus.first_byte),
      .csr_write  (csr_bus.valid),
      .csr_data   (csr_bus.file_length),
      .beat       (beat),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr)
   );

   // palette writes and pixel reads never fall on the same edge for one file
   pisd_ram #(
      .WIDTH (WORD_W),
      .DEPTH (PAL_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pisd_out u_out (
      .clock    (clock),
      .reset    (reset),
      .beat     (beat),
      .rd_data  (rd_data),
      .in_ready (in_ready),
      .rsp      (rsp_bus)
   );

endmodule

FILE: rtl/pisd_checker.sv
// ---------------------------------------------------------------------------
// pisd_checker
// Port-level checks on the result channel of the decoder, bound to the top.
// ---------------------------------------------------------------------------
`include "palette_image_stream_decoder_assert.svh"

module pisd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  status,
   input logic [7:0]  red,
   input logic [7:0]  green,
   input logic [7:0]  blue,
   input logic [7:0]  alpha,
   input logic [12:0] image_width,
   input logic [12:0] image_height,
   input logic        last_pixel
);
   import pisd_pkg::*;

   logic [61:0] rsp_payload;
   logic        rgba_blank;
   logic        size_blank;
   logic        size_legal;

   assign rsp_payload = {status, red, green, blue, alpha, image_width, image_height,
                         last_pixel};
   assign rgba_blank  = red == 8'd0 && green == 8'd0 && blue == 8'd0 && alpha == 8'd0;
   assign size_blank  = image_width == 13'd0 && image_height == 13'd0;
   assign size_legal  = image_width != 13'd0 && image_height != 13'd0 &&
                        image_width <= 13'(MAX_DIMENSION) &&
                        image_height <= 13'(MAX_DIMENSION);

   `PISD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   `PISD_ASSERT_NOW(a_non_pixel_blank, rsp_valid && status != ST_PIXEL, rgba_blank && !last_pixel)

   `PISD_ASSERT_NOW(a_size_only_on_header, rsp_valid && status != ST_HEADER_OK, size_blank)

   `PISD_ASSERT_NOW(a_header_size_legal, rsp_valid && status == ST_HEADER_OK, size_legal)

endmodule

bind palette_image_stream_decoder pisd_checker u_pisd_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .status       (rsp_bus.status),
   .red          (rsp_bus.red),
   .green        (rsp_bus.green),
   .blue         (rsp_bus.blue),
   .alpha        (rsp_bus.alpha),
   .image_width  (rsp_bus.image_width),
   .image_height (rsp_bus.image_height),
   .last_pixel   (rsp_bus.last_pixel)
);
